// ===== design/sgf_pkg.sv =====
// ----------------------------------------------------------------------------
// sgf_pkg
// Shared constants and types of the Savitzky-Golay FIR filter unit: field
// widths, operation codes, register map and the cell control bundle.
// ----------------------------------------------------------------------------
package sgf_pkg;

    localparam int MAX_TAPS_DEFAULT        = 16;
    localparam int SAMPLE_BITS_DEFAULT     = 16;
    localparam int COEFF_FRAC_BITS_DEFAULT = 12;

    localparam int COEFF_BITS       = 16;
    localparam int OUT_BITS         = 24;
    localparam int TAP_COUNT_BITS   = 5;
    localparam int COEFF_INDEX_BITS = 4;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 5'd7;
    localparam logic [APB_ADDR_BITS-1:0]  ADDR_TAP_COUNT  = 3'd0;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic sample_shift;  // rotate the sample ring one position up
        logic coeff_shift;   // rotate the coefficient ring one position down
        logic active;        // cell lies inside the current window
        logic last;          // cell is the top of the current window
    } cell_ctrl_t;

endpackage

// ===== design/sgf_cell.sv =====
// ----------------------------------------------------------------------------
// sgf_cell
// One tap cell: holds one slot of the sample ring and one coefficient.
// Samples rotate upward and coefficients downward within the active window.
// ----------------------------------------------------------------------------
module sgf_cell #(
    parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sgf_pkg::cell_ctrl_t                  ctrl,
    input  logic                                 sample_wr,
    input  logic signed [SAMPLE_BITS-1:0]        sample_wdata,
    input  logic                                 coeff_wr,
    input  logic signed [sgf_pkg::COEFF_BITS-1:0] coeff_wdata,
    input  logic signed [SAMPLE_BITS-1:0]        sample_from_lower,
    input  logic signed [sgf_pkg::COEFF_BITS-1:0] coeff_from_upper,
    input  logic signed [sgf_pkg::COEFF_BITS-1:0] coeff_from_first,
    output logic signed [SAMPLE_BITS-1:0]        sample_q,
    output logic signed [sgf_pkg::COEFF_BITS-1:0] coeff_q
);

    logic signed [SAMPLE_BITS-1:0]         sample_reg;
    logic signed [SAMPLE_BITS-1:0]         sample_next;
    logic signed [sgf_pkg::COEFF_BITS-1:0] coeff_reg;
    logic signed [sgf_pkg::COEFF_BITS-1:0] coeff_next;

    always_comb begin
        sample_next = sample_reg;
        if (sample_wr) begin
            sample_next = sample_wdata;
        end else if (ctrl.sample_shift && ctrl.active) begin
            sample_next = sample_from_lower;
        end
    end

    always_comb begin
        coeff_next = coeff_reg;
        if (coeff_wr) begin
            coeff_next = coeff_wdata;
        end else if (ctrl.coeff_shift && ctrl.active) begin
            // top of the window wraps around to the first cell
            coeff_next = ctrl.last ? coeff_from_first : coeff_from_upper;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            coeff_reg  <= '0;
        end else begin
            sample_reg <= sample_next;
            coeff_reg  <= coeff_next;
        end
    end

    assign sample_q = sample_reg;
    assign coeff_q  = coeff_reg;

endmodule

// ===== design/sgf_mac.sv =====
// ----------------------------------------------------------------------------
// sgf_mac
// Multiply-accumulate unit fed from the first cell: registered product,
// then accumulate in the following cycle.
// ----------------------------------------------------------------------------
module sgf_mac #(
    parameter int MAX_TAPS    = sgf_pkg::MAX_TAPS_DEFAULT,
    parameter int SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  clear,
    input  logic                                  issue,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic signed [sgf_pkg::COEFF_BITS-1:0] coeff,
    output logic signed [SAMPLE_BITS+sgf_pkg::COEFF_BITS+$clog2(MAX_TAPS)-1:0] acc,
    output logic                                  busy
);

    localparam int PROD_W = SAMPLE_BITS + sgf_pkg::COEFF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_vld_reg;
    logic                     prod_vld_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        prod_next     = sample * coeff;
        prod_vld_next = issue;
        acc_next      = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= prod_vld_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

    // a cleared accumulator starts empty with no product in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> (acc_reg == '0) && !prod_vld_reg)
        else $error("sgf_mac: accumulator not empty after clear");

endmodule

// ===== design/savitzky_golay_fir_filter_unit.sv =====
// ----------------------------------------------------------------------------
// savitzky_golay_fir_filter_unit
// Circular-buffer FIR filter with a loadable coefficient table, built as a
// row of tap cells that rotate the sample ring and coefficients past a
// single multiply-accumulate unit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   s_      | in        | s_valid / s_ready  | op, sample, coeff_index, value
//   m_      | out       | m_valid / m_ready  | filtered
//   apb     | in        | psel/penable/pready| tap_count at byte address 0
//
// A coefficient-load word is written into its cell in ST_IDLE. A sample word
// with window length n runs PRE, COMP, POST, DRAIN and FIN (PRE and POST
// only when the head slot is not 0). The sample ring turns one position per
// cycle in the cell row, 2n positions (n from slot 0); coefficients turn once.
// Reset (aresetn low, synchronous) clears ring, table, head and tap_count=7.
// A finished result waits in the output register; s_ready returns once it
// has moved there, so a stalled m_ready holds the next word in its last step.
// ----------------------------------------------------------------------------
module savitzky_golay_fir_filter_unit #(
    parameter int MAX_TAPS        = sgf_pkg::MAX_TAPS_DEFAULT,
    parameter int SAMPLE_BITS     = sgf_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COEFF_FRAC_BITS = sgf_pkg::COEFF_FRAC_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,

    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic                                        s_op,
    input  logic signed [SAMPLE_BITS-1:0]               s_sample,
    input  logic [sgf_pkg::COEFF_INDEX_BITS-1:0]        s_coeff_index,
    input  logic signed [sgf_pkg::COEFF_BITS-1:0]       s_coeff_value,

    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [sgf_pkg::OUT_BITS-1:0]         m_filtered,

    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [sgf_pkg::APB_ADDR_BITS-1:0]           paddr,
    input  logic [sgf_pkg::APB_DATA_BITS-1:0]           pwdata,
    output logic [sgf_pkg::APB_DATA_BITS-1:0]           prdata,
    output logic                                        pready
);

    localparam int HW    = $clog2(MAX_TAPS);
    localparam int NW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = SAMPLE_BITS + sgf_pkg::COEFF_BITS + $clog2(MAX_TAPS);
    localparam int OW    = sgf_pkg::OUT_BITS;
    localparam int DW    = sgf_pkg::APB_DATA_BITS;
    localparam int TW    = sgf_pkg::TAP_COUNT_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_COMP  = 3'd2;
    localparam logic [2:0] ST_POST  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [TW-1:0]  tap_count_reg;
    logic [TW-1:0]  tap_count_next;
    logic [HW-1:0]  ring_head_reg;
    logic [HW-1:0]  ring_head_next;
    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [HW-1:0]  cnt_reg;
    logic [HW-1:0]  cnt_next;
    logic [HW-1:0]  head_reg;
    logic [HW-1:0]  head_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    logic signed [OW-1:0] m_filtered_reg;
    logic signed [OW-1:0] m_filtered_next;

    logic [NW-1:0]  n_eff;
    logic [HW-1:0]  n_last;
    logic [HW-1:0]  head_eff;
    logic           cfg_write;
    logic           accept_sample;
    logic           accept_load;
    logic           sample_shift;
    logic           coeff_shift;
    logic           mac_clear;
    logic           mac_issue;
    logic           mac_busy;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [ACC_W-1:0] acc_shift;

    logic signed [SAMPLE_BITS-1:0]         cell_sample [MAX_TAPS];
    logic signed [sgf_pkg::COEFF_BITS-1:0] cell_coeff  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]         ring_tail;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == sgf_pkg::ADDR_TAP_COUNT);
    assign prdata    = (paddr == sgf_pkg::ADDR_TAP_COUNT) ? DW'(tap_count_reg) : '0;

    always_comb begin
        tap_count_next = tap_count_reg;
        if (cfg_write) begin
            tap_count_next = pwdata[TW-1:0];
        end
    end

    // ---------------- window length and head slot ----------------
    always_comb begin
        if (tap_count_reg == '0) begin
            n_eff = NW'(1);
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            n_eff = NW'(MAX_TAPS);
        end else begin
            n_eff = NW'(tap_count_reg);
        end
    end

    assign n_last   = HW'(n_eff - NW'(1));
    assign head_eff = (NW'(ring_head_reg) >= n_eff) ? '0 : ring_head_reg;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept_sample = s_valid && s_ready && (s_op == sgf_pkg::OP_FILTER);
    assign accept_load   = s_valid && s_ready && (s_op == sgf_pkg::OP_LOAD);

    assign acc_shift = mac_acc >>> COEFF_FRAC_BITS;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        ring_head_next  = ring_head_reg;
        sample_shift    = 1'b0;
        coeff_shift     = 1'b0;
        mac_clear       = 1'b0;
        mac_issue       = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        m_filtered_next = m_filtered_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept_sample) begin
                    mac_clear      = 1'b1;
                    head_next      = head_eff;
                    ring_head_next = (head_eff == n_last) ? '0 : head_eff + 1'b1;
                    if (head_eff == '0) begin
                        state_next = ST_COMP;
                        cnt_next   = n_last;
                    end else begin
                        // pre-roll the samples so the head slot reaches cell 0
                        state_next = ST_PRE;
                        cnt_next   = HW'(n_eff - NW'(head_eff) - NW'(1));
                    end
                end
            end
            ST_PRE: begin
                sample_shift = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_COMP;
                    cnt_next   = n_last;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_COMP: begin
                sample_shift = 1'b1;
                coeff_shift  = 1'b1;
                mac_issue    = 1'b1;
                if (cnt_reg == '0) begin
                    if (head_reg == '0) begin
                        state_next = ST_DRAIN;
                    end else begin
                        // finish the turn so each sample lands in its own slot
                        state_next = ST_POST;
                        cnt_next   = head_reg - 1'b1;
                    end
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_POST: begin
                sample_shift = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = OW'(acc_shift);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= sgf_pkg::TAP_COUNT_RESET;
            ring_head_reg <= '0;
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
        end else begin
            tap_count_reg <= tap_count_next;
            ring_head_reg <= ring_head_next;
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        head_reg       <= head_next;
        m_filtered_reg <= m_filtered_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    // ---------------- cell row ----------------
    assign ring_tail = cell_sample[n_last];

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        localparam logic [NW-1:0] JN = NW'(j);

        sgf_pkg::cell_ctrl_t                   ctrl;
        logic signed [SAMPLE_BITS-1:0]         from_lower;
        logic signed [sgf_pkg::COEFF_BITS-1:0] from_upper;

        assign ctrl.sample_shift = sample_shift;
        assign ctrl.coeff_shift  = coeff_shift;
        assign ctrl.active       = (JN < n_eff);
        assign ctrl.last         = ((JN + NW'(1)) == n_eff);

        if (j == 0) begin : g_first
            assign from_lower = ring_tail;
        end else begin : g_mid
            assign from_lower = cell_sample[j-1];
        end

        if (j == MAX_TAPS - 1) begin : g_top
            assign from_upper = cell_coeff[0];
        end else begin : g_below
            assign from_upper = cell_coeff[j+1];
        end

        sgf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .aclk              (aclk),
            .aresetn           (aresetn),
            .ctrl              (ctrl),
            .sample_wr         (accept_sample && (head_eff == HW'(j))),
            .sample_wdata      (s_sample),
            .coeff_wr          (accept_load && (int'(s_coeff_index) == j)),
            .coeff_wdata       (s_coeff_value),
            .sample_from_lower (from_lower),
            .coeff_from_upper  (from_upper),
            .coeff_from_first  (cell_coeff[0]),
            .sample_q          (cell_sample[j]),
            .coeff_q           (cell_coeff[j])
        );
    end

    sgf_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (mac_clear),
        .issue   (mac_issue),
        .sample  (cell_sample[0]),
        .coeff   (cell_coeff[0]),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    // ---------------- checks ----------------
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> !mac_busy)
        else $error("filter: product still in flight at finish");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("filter: result loaded outside finish step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (NW'(ring_head_reg) < n_eff))
        else $error("filter: ring head left the window");

endmodule
